@@ rtl/lrs_pkg.sv @@
// shared types and constants for the line raster stepper
// no dependencies; imported by every rtl module of the block
`default_nettype none

package lrs_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int QUEUE_DEPTH    = 2;

	typedef enum logic {
		MODE_START   = 1'b0,
		MODE_ADVANCE = 1'b1
	} mode_t;

	// queue entry: mode, four coordinates, two absolute deltas, two direction bits
	function automatic int entry_bits(input int cw);
		return 6 * cw + 5;
	endfunction

	// round a bit count up to whole bytes
	function automatic int byte_pad(input int bits);
		return ((bits + 7) / 8) * 8;
	endfunction

endpackage

`default_nettype wire

@@ rtl/lrs_front.sv @@
// front end: takes input items, classifies start/advance and precomputes deltas
// depends on lrs_pkg
`default_nettype none

module lrs_front import lrs_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire mode_t                             mode,
	input  wire logic [COORD_BITS-1:0]             x_start,
	input  wire logic [COORD_BITS-1:0]             y_start,
	input  wire logic [COORD_BITS-1:0]             x_end,
	input  wire logic [COORD_BITS-1:0]             y_end,
	output logic                                   push,
	input  wire logic                              q_ready,
	output logic [entry_bits(COORD_BITS)-1:0]      entry
);

	localparam int W = COORD_BITS;

	typedef struct packed {
		mode_t        mode;
		logic [W-1:0] x_start;
		logic [W-1:0] y_start;
		logic [W-1:0] x_end;
		logic [W-1:0] y_end;
		logic [W:0]   abs_dx;
		logic [W:0]   abs_dy;
		logic         dir_x_neg;
		logic         dir_y_neg;
	} entry_t;

	logic [W:0] dx;
	logic [W:0] dy;
	entry_t     e;

	// deltas one bit wider than the coordinates, so they never wrap
	assign dx = {x_end[W-1], x_end} - {x_start[W-1], x_start};
	assign dy = {y_end[W-1], y_end} - {y_start[W-1], y_start};

	always_comb begin
		e.mode      = mode;
		e.x_start   = x_start;
		e.y_start   = y_start;
		e.x_end     = x_end;
		e.y_end     = y_end;
		e.dir_x_neg = dx[W];
		e.dir_y_neg = dy[W];
		e.abs_dx    = dx[W] ? (~dx + 1'b1) : dx;
		e.abs_dy    = dy[W] ? (~dy + 1'b1) : dy;
	end

	assign entry    = e;
	assign in_ready = q_ready;
	assign push     = in_valid & q_ready;

endmodule

`default_nettype wire

@@ rtl/lrs_queue.sv @@
// short fifo between front and back, one push and one pop per cycle
// depends on lrs_pkg
`default_nettype none

module lrs_queue import lrs_pkg::*; #(
	parameter int WIDTH = entry_bits(COORD_BITS_DEF)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  wr_ready,
	input  wire logic             pop,
	output logic                  rd_valid,
	output logic [WIDTH-1:0]      rd_data
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign wr_ready = (count_q != CW'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH)) else $error("queue count beyond depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0) else $error("pop from empty queue");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1) else $error("queue count lost a push");

endmodule

`default_nettype wire

@@ rtl/lrs_back.sv @@
// back end: bresenham stepper state, error update and registered result
// depends on lrs_pkg
`default_nettype none

module lrs_back import lrs_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_valid,
	input  wire logic [entry_bits(COORD_BITS)-1:0] q_data,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [COORD_BITS-1:0]              pixel_x,
	output logic [COORD_BITS-1:0]              pixel_y,
	output logic                               last_pixel,
	output logic                               idle
);

	localparam int W  = COORD_BITS;
	localparam int EW = COORD_BITS + 3;

	typedef struct packed {
		mode_t        mode;
		logic [W-1:0] x_start;
		logic [W-1:0] y_start;
		logic [W-1:0] x_end;
		logic [W-1:0] y_end;
		logic [W:0]   abs_dx;
		logic [W:0]   abs_dy;
		logic         dir_x_neg;
		logic         dir_y_neg;
	} entry_t;

	entry_t e;

	// stepper state
	logic [W-1:0]  cur_x_q, cur_y_q, end_x_q, end_y_q;
	logic [EW-1:0] err_q, inc_pos_q, inc_neg_q;
	logic          dir_x_neg_q, dir_y_neg_q, y_major_q, active_q;
	// result register
	logic          out_valid_q, last_q, idle_q;
	logic [W-1:0]  px_q, py_q;

	// start path
	logic          s_y_major;
	logic [W:0]    s_major, s_minor;
	logic [EW-1:0] s_two_minor, s_err_init, s_inc_neg;
	// advance path
	logic          err_nonneg, step_x, step_y;
	logic [W-1:0]  nx, ny;
	logic          a_last;

	assign e   = entry_t'(q_data);
	assign pop = q_valid & (~out_valid_q | out_ready);

	always_comb begin
		s_y_major   = e.abs_dy > e.abs_dx;
		s_major     = s_y_major ? e.abs_dy : e.abs_dx;
		s_minor     = s_y_major ? e.abs_dx : e.abs_dy;
		s_two_minor = {1'b0, s_minor, 1'b0};
		s_err_init  = s_two_minor - {2'b00, s_major};
		s_inc_neg   = s_two_minor - {1'b0, s_major, 1'b0};
	end

	always_comb begin
		err_nonneg = ~err_q[EW-1];
		step_x     = y_major_q ? err_nonneg : 1'b1;
		step_y     = y_major_q ? 1'b1 : err_nonneg;
		nx = step_x ? cur_x_q + {{(W-1){dir_x_neg_q}}, 1'b1} : cur_x_q;
		ny = step_y ? cur_y_q + {{(W-1){dir_y_neg_q}}, 1'b1} : cur_y_q;
		a_last = y_major_q ? (ny == end_y_q) : (nx == end_x_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			end_x_q     <= '0;
			end_y_q     <= '0;
			err_q       <= '0;
			inc_pos_q   <= '0;
			inc_neg_q   <= '0;
			dir_x_neg_q <= 1'b0;
			dir_y_neg_q <= 1'b0;
			y_major_q   <= 1'b0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			px_q        <= '0;
			py_q        <= '0;
			last_q      <= 1'b0;
			idle_q      <= 1'b0;
		end else begin
			if (pop) begin
				case (e.mode)
					MODE_START: begin
						out_valid_q <= 1'b1;
						cur_x_q     <= e.x_start;
						cur_y_q     <= e.y_start;
						end_x_q     <= e.x_end;
						end_y_q     <= e.y_end;
						dir_x_neg_q <= e.dir_x_neg;
						dir_y_neg_q <= e.dir_y_neg;
						y_major_q   <= s_y_major;
						err_q       <= s_err_init;
						inc_pos_q   <= s_two_minor;
						inc_neg_q   <= s_inc_neg;
						active_q    <= (s_major != '0);
						px_q        <= e.x_start;
						py_q        <= e.y_start;
						last_q      <= (s_major == '0);
						idle_q      <= 1'b0;
					end
					MODE_ADVANCE: begin
						out_valid_q <= 1'b1;
						if (active_q) begin
							cur_x_q  <= nx;
							cur_y_q  <= ny;
							err_q    <= err_q + (err_nonneg ? inc_neg_q : inc_pos_q);
							active_q <= ~a_last;
							px_q     <= nx;
							py_q     <= ny;
							last_q   <= a_last;
							idle_q   <= 1'b0;
						end else begin
							// no line: repeat the current pixel
							px_q   <= cur_x_q;
							py_q   <= cur_y_q;
							last_q <= 1'b0;
							idle_q <= 1'b1;
						end
					end
					default: begin
						out_valid_q <= 1'b0;
					end
				endcase
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_x    = px_q;
	assign pixel_y    = py_q;
	assign last_pixel = last_q;
	assign idle       = idle_q;

	a_idle_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && idle_q |-> !last_q) else $error("idle result flagged as last pixel");
	a_active_not_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (y_major_q ? (cur_y_q != end_y_q) : (cur_x_q != end_x_q)))
		else $error("line active at its end point");
	a_point_line_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		pop && e.mode == MODE_START && s_major == '0 |=> !active_q && last_q)
		else $error("single point line left active");

endmodule

`default_nettype wire

@@ rtl/line_raster_stepper.sv @@
// line raster stepper: bresenham line rasterizer over all eight octants
// an accepted item is written into the queue; its result then goes to the result register
// throughput: one item per cycle while the sink is ready; a stalled sink backs up the queue and the input
// reset clears every register but the queue slots: no active line, current pixel (0, 0), queue empty
// depends on lrs_pkg, lrs_front, lrs_queue, lrs_back
`default_nettype none

module line_raster_stepper import lrs_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	// input items
	input  wire logic                                    s_axis_tvalid,
	output logic                                         s_axis_tready,
	// x_start, y_start, x_end, y_end from bit 0 up, zero padded to bytes
	input  wire logic [byte_pad(4*COORD_BITS)-1:0]       s_axis_tdata,
	// mode
	input  wire logic                                    s_axis_tuser,
	// result items
	output logic                                         m_axis_tvalid,
	input  wire logic                                    m_axis_tready,
	// pixel_x, pixel_y from bit 0 up, zero padded to bytes
	output logic [byte_pad(2*COORD_BITS)-1:0]            m_axis_tdata,
	// last_pixel
	output logic                                         m_axis_tlast,
	// idle
	output logic                                         m_axis_tuser
);

	localparam int W     = COORD_BITS;
	localparam int EBITS = entry_bits(COORD_BITS);
	localparam int OTDW  = byte_pad(2*COORD_BITS);

	// front to queue
	logic             push;
	logic             q_wr_ready;
	logic [EBITS-1:0] f_entry;
	// queue to back
	logic             q_rd_valid;
	logic [EBITS-1:0] q_rd_data;
	logic             pop;
	// back result
	logic [W-1:0]     pixel_x, pixel_y;

	// front: classifies the item and works out deltas and step directions
	lrs_front #(.COORD_BITS(COORD_BITS)) u_front (
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.mode     (mode_t'(s_axis_tuser)),
		.x_start  (s_axis_tdata[W-1:0]),
		.y_start  (s_axis_tdata[2*W-1:W]),
		.x_end    (s_axis_tdata[3*W-1:2*W]),
		.y_end    (s_axis_tdata[4*W-1:3*W]),
		.push     (push),
		.q_ready  (q_wr_ready),
		.entry    (f_entry)
	);

	// two-entry queue lets input and output stall independently
	lrs_queue #(.WIDTH(EBITS)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  (f_entry),
		.wr_ready (q_wr_ready),
		.pop      (pop),
		.rd_valid (q_rd_valid),
		.rd_data  (q_rd_data)
	);

	// back: holds the line state and gives one result pixel per popped item
	lrs_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_rd_valid),
		.q_data     (q_rd_data),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last_pixel (m_axis_tlast),
		.idle       (m_axis_tuser)
	);

	// pad bits above the two coordinates read as zero
	assign m_axis_tdata = OTDW'({pixel_y, pixel_x});

endmodule

`default_nettype wire

@@ verif/lrs_pixel_checker.sv @@
// pixel stream checker for the line raster stepper: own bresenham predictor plus in-order compare
// depends on lrs_pkg for mode_t and byte_pad; watches both stream channels of the block
module lrs_pixel_checker import lrs_pkg::*; #(
	parameter int CW = COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [byte_pad(4*CW)-1:0]     in_data,
	input  logic                          in_mode,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [byte_pad(2*CW)-1:0]     out_data,
	input  logic                          out_last,
	input  logic                          out_idle,
	output int                            mismatch_count,
	output int                            pixels_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IN_W = byte_pad(4*CW);

	typedef struct packed {
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic                 last;
		logic                 idle;
	} pixel_t;

	pixel_t expected_pixels[$];

	// predictor state
	logic signed [CW-1:0] cur_x, cur_y, end_x, end_y;
	logic [CW:0]          abs_dx, abs_dy;
	logic signed [CW+2:0] err_term;
	logic                 dir_x_neg, dir_y_neg, y_major, line_active;

	pixel_t               want, got, next_pixel;

	initial begin
		mismatch_count = 0;
		pixels_owed    = 0;
	end

	task automatic step_raster(input mode_t m, input logic [IN_W-1:0] d, output pixel_t p);
		int   xs, ys, xe, ye, dx, dy, major, minor;
		logic last;
		if (m == MODE_START) begin
			xs = int'($signed(d[CW-1:0]));
			ys = int'($signed(d[2*CW-1:CW]));
			xe = int'($signed(d[3*CW-1:2*CW]));
			ye = int'($signed(d[4*CW-1:3*CW]));
			dx = xe - xs;
			dy = ye - ys;
			dir_x_neg = dx < 0;
			dir_y_neg = dy < 0;
			abs_dx = (CW+1)'(dir_x_neg ? -dx : dx);
			abs_dy = (CW+1)'(dir_y_neg ? -dy : dy);
			// tie goes to x as major axis
			y_major = abs_dy > abs_dx;
			major = y_major ? int'(abs_dy) : int'(abs_dx);
			minor = y_major ? int'(abs_dx) : int'(abs_dy);
			err_term = (CW+3)'(2 * minor - major);
			cur_x = CW'(xs);
			cur_y = CW'(ys);
			end_x = CW'(xe);
			end_y = CW'(ye);
			last = (major == 0);
			line_active = !last;
			p = '{cur_x, cur_y, last, 1'b0};
		end else if (!line_active) begin
			p = '{cur_x, cur_y, 1'b0, 1'b1};
		end else begin
			major = y_major ? int'(abs_dy) : int'(abs_dx);
			minor = y_major ? int'(abs_dx) : int'(abs_dy);
			if (err_term >= 0) begin
				if (y_major)
					cur_x = CW'(dir_x_neg ? int'(cur_x) - 1 : int'(cur_x) + 1);
				else
					cur_y = CW'(dir_y_neg ? int'(cur_y) - 1 : int'(cur_y) + 1);
				err_term = (CW+3)'(int'(err_term) + 2 * minor - 2 * major);
			end else begin
				err_term = (CW+3)'(int'(err_term) + 2 * minor);
			end
			if (y_major)
				cur_y = CW'(dir_y_neg ? int'(cur_y) - 1 : int'(cur_y) + 1);
			else
				cur_x = CW'(dir_x_neg ? int'(cur_x) - 1 : int'(cur_x) + 1);
			last = y_major ? (cur_y == end_y) : (cur_x == end_x);
			if (last)
				line_active = 1'b0;
			p = '{cur_x, cur_y, last, 1'b0};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x       = '0;
			cur_y       = '0;
			end_x       = '0;
			end_y       = '0;
			abs_dx      = '0;
			abs_dy      = '0;
			err_term    = '0;
			dir_x_neg   = 1'b0;
			dir_y_neg   = 1'b0;
			y_major     = 1'b0;
			line_active = 1'b0;
			expected_pixels.delete();
			pixels_owed <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{out_data[CW-1:0], out_data[2*CW-1:CW], out_last, out_idle};
				if (expected_pixels.size() == 0) begin
					mismatch_count <= mismatch_count + 1;
					if (mismatch_count < 10)
						$display("unexpected pixel: x=%0d y=%0d last=%b idle=%b",
							got.px, got.py, got.last, got.idle);
				end else begin
					want = expected_pixels.pop_front();
					if (got.px !== want.px || got.py !== want.py ||
						got.last !== want.last || got.idle !== want.idle) begin
						mismatch_count <= mismatch_count + 1;
						if (mismatch_count < 10)
							$display({"pixel mismatch: expected x=%0d y=%0d last=%b idle=%b,",
								" got x=%0d y=%0d last=%b idle=%b"},
								want.px, want.py, want.last, want.idle,
								got.px, got.py, got.last, got.idle);
					end
				end
			end
			if (in_valid && in_ready) begin
				step_raster(mode_t'(in_mode), in_data, next_pixel);
				expected_pixels.push_back(next_pixel);
			end
			pixels_owed <= expected_pixels.size();
		end
	end

endmodule

@@ verif/tb_line_raster_stepper.sv @@
// testbench top for line_raster_stepper: drives command items and a stalling pixel sink
// depends on lrs_pkg, the rtl of the block and lrs_pixel_checker, which does all the checking
module tb_line_raster_stepper;
	timeunit 1ns;
	timeprecision 1ps;

	import lrs_pkg::*;

	localparam int CW         = 12;
	localparam int IN_W       = byte_pad(4*CW);
	localparam int OUT_W      = byte_pad(2*CW);
	localparam int COORD_LO   = -(1 << (CW-1));
	localparam int COORD_HI   = (1 << (CW-1)) - 1;
	// directed part plus the random part
	localparam int ITEM_GOAL  = 850;
	localparam int HOLD_LEN   = 400;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	// x_start, y_start, x_end, y_end from bit 0 up
	logic [IN_W-1:0]   s_axis_tdata;
	// mode
	logic              s_axis_tuser;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	// pixel_x, pixel_y from bit 0 up
	logic [OUT_W-1:0]  m_axis_tdata;
	// last_pixel
	logic              m_axis_tlast;
	// idle
	logic              m_axis_tuser;

	int                mismatch_count;
	int                pixels_owed;

	// sender bookkeeping
	int                items_sent;
	int                burst_left;
	int                hold_requests;

	// receiver bookkeeping, touched only by the sink process
	int                hold_served;
	int                hold_left;
	int                sink_phase;
	int                sink_phase_left;
	int                sink_tick;

	line_raster_stepper #(
		.COORD_BITS(CW)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	lrs_pixel_checker #(
		.CW(CW)
	) pixel_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.in_data        (s_axis_tdata),
		.in_mode        (s_axis_tuser),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_data       (m_axis_tdata),
		.out_last       (m_axis_tlast),
		.out_idle       (m_axis_tuser),
		.mismatch_count (mismatch_count),
		.pixels_owed    (pixels_owed)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// hard stop well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("tb_line_raster_stepper: FAIL");
		$finish;
	end

	// full-range coordinate, leaning on the two extremes now and then
	function automatic int pick_coord();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return COORD_LO;
		if (r == 1)
			return COORD_HI;
		return int'($urandom_range(0, COORD_HI - COORD_LO)) + COORD_LO;
	endfunction

	// offer one command item, with burst/gap idling in front of it
	task automatic send_item(input mode_t m, input int xs, input int ys, input int xe, input int ye);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			// now and then a long stretch with no gaps at all
			burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 30);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= m;
		s_axis_tdata  <= IN_W'({CW'(ye), CW'(xe), CW'(ys), CW'(xs)});
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic send_start(input int xs, input int ys, input int xe, input int ye);
		send_item(MODE_START, xs, ys, xe, ye);
	endtask

	// endpoint bits of an advance are don't-care, so fill them with noise
	task automatic send_advance();
		send_item(MODE_ADVANCE, pick_coord(), pick_coord(), pick_coord(), pick_coord());
	endtask

	// stop offering and wait until the checker owes nothing or max_cycles have passed
	task automatic wait_drained(input int max_cycles);
		int waited;
		waited = 0;
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (pixels_owed != 0 && waited < max_cycles);
	endtask

	// short line around a random point, mostly walked to its end
	task automatic draw_line(input int span);
		int xs, ys, xe, ye, dx, dy, major, steps, r;
		xs = pick_coord();
		ys = pick_coord();
		dx = int'($urandom_range(0, 2*span)) - span;
		dy = int'($urandom_range(0, 2*span)) - span;
		// mirror the delta when the end would leave the coordinate range
		xe = (xs + dx > COORD_HI || xs + dx < COORD_LO) ? xs - dx : xs + dx;
		ye = (ys + dy > COORD_HI || ys + dy < COORD_LO) ? ys - dy : ys + dy;
		major = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx) : (dy < 0 ? -dy : dy);
		send_start(xs, ys, xe, ye);
		steps = major;
		r = $urandom_range(0, 99);
		if (r < 15 && major > 0)
			steps = $urandom_range(0, major - 1);     // cut short by the next start
		else if (r < 45)
			steps = major + $urandom_range(1, 3);     // run past the end into idle repeats
		repeat (steps) send_advance();
	endtask

	// pixel sink: changing stall patterns plus the long hold-offs on request
	initial begin
		m_axis_tready   = 1'b0;
		hold_served     = 0;
		hold_left       = 0;
		sink_phase      = 0;
		sink_phase_left = 0;
		sink_tick       = 0;
		forever begin
			@(posedge clk);
			sink_tick++;
			if (hold_left == 0 && hold_served != hold_requests) begin
				hold_served++;
				hold_left = HOLD_LEN;
			end
			if (sink_phase_left == 0) begin
				sink_phase      = $urandom_range(0, 3);
				sink_phase_left = $urandom_range(20, 200);
			end
			sink_phase_left--;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				case (sink_phase)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 3) != 0);
					2: m_axis_tready <= ($urandom_range(0, 9) < 3);
					default: m_axis_tready <= (sink_tick % 3 != 0);
				endcase
			end
		end
	end

	// command stimulus and verdict
	initial begin
		int  r;
		bit  first_hold_done, second_hold_done, drain_done;
		arst_n          = 1'b0;
		s_axis_tvalid   = 1'b0;
		s_axis_tdata    = '0;
		s_axis_tuser    = 1'b0;
		items_sent      = 0;
		burst_left      = 0;
		hold_requests   = 0;
		first_hold_done  = 1'b0;
		second_hold_done = 1'b0;
		drain_done       = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// advance right after reset repeats pixel (0, 0) as idle
		send_advance();
		// single-point line at a corner, then an idle repeat of it
		send_start(COORD_HI, COORD_LO, COORD_HI, COORD_LO);
		send_advance();
		// full-span diagonals both ways, tie keeps x as major
		send_start(COORD_LO, COORD_LO, COORD_HI, COORD_HI);
		send_advance();
		send_advance();
		send_start(COORD_HI, COORD_HI, COORD_LO, COORD_LO);
		send_advance();
		// horizontal line walked to its end, then one advance past it
		send_start(0, 5, 3, 5);
		repeat (4) send_advance();
		// vertical line going down
		send_start(5, 0, 5, -3);
		repeat (3) send_advance();
		// steep line, y major
		send_start(0, 0, 2, 5);
		repeat (5) send_advance();

		while (items_sent < ITEM_GOAL) begin
			// sink holds off while commands keep coming, so the block backs up
			if (!first_hold_done && items_sent >= 300) begin
				hold_requests++;
				first_hold_done = 1'b1;
			end
			if (!second_hold_done && items_sent >= 650) begin
				hold_requests++;
				second_hold_done = 1'b1;
			end
			// one full pause of the sender until every pixel is out
			if (!drain_done && items_sent >= 500) begin
				wait_drained(20000);
				drain_done = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 70) begin
				draw_line(($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12));
			end else if (r < 85) begin
				// endpoints anywhere, only a few pixels of it
				send_start(pick_coord(), pick_coord(), pick_coord(), pick_coord());
				repeat ($urandom_range(0, 3)) send_advance();
			end else begin
				repeat ($urandom_range(1, 4)) send_advance();
			end
		end

		wait_drained(20000);
		// let any stray extra pixel show up before the verdict
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pixels_owed == 0) begin
			$display("tb_line_raster_stepper: PASS");
		end else begin
			$display("tb_line_raster_stepper: FAIL");
		end
		$finish;
	end

endmodule

@@ line_raster_stepper.f @@
rtl/lrs_pkg.sv
rtl/lrs_front.sv
rtl/lrs_queue.sv
rtl/lrs_back.sv
rtl/line_raster_stepper.sv
verif/lrs_pixel_checker.sv
verif/tb_line_raster_stepper.sv
